// ===== design/tcqt_pkg.sv =====
package tcqt_pkg;

	// Request opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// Configuration register indexes
	localparam logic [0:0] CFG_TICK_MILLIS = 1'd0;
	localparam logic [0:0] CFG_MIN_QUANTUM = 1'd1;

	// Reset values
	localparam logic [9:0]  TICK_MILLIS_RST = 10'd10;
	localparam logic [15:0] MIN_QUANTUM_RST = 16'd0;
	localparam logic [15:0] YEAR_RST        = 16'd2000;
	localparam logic [3:0]  MONTH_RST       = 4'd1;
	localparam logic [4:0]  DAY_RST         = 5'd1;

	// Calendar limits
	localparam logic [10:0] MS_PER_SEC  = 11'd1000;
	localparam logic [9:0]  MILLI_MAX   = 10'd999;
	localparam logic [6:0]  SEC_LIMIT   = 7'd60;
	localparam logic [6:0]  MIN_LIMIT   = 7'd60;
	localparam logic [5:0]  HOUR_LIMIT  = 6'd24;
	localparam logic [4:0]  MONTH_LAST  = 5'd12;
	localparam logic [16:0] SCHED_BIAS  = 17'd10;

	// Divisibility by 25: y * inv(25) mod 2^16 falls at or below 65535/25 exactly
	// when y is a multiple of 25.
	localparam logic [15:0] INV25      = 16'd23593;
	localparam logic [15:0] DIV25_MAX  = 16'd2621;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  milli;
	} tod_t;

	typedef struct packed {
		logic [31:0] uptime_ms;
		tod_t        tod;
		logic        schedule_now;
	} res_t;

	// Gregorian rule: multiple of 400, or of 4 but not of 100
	function automatic logic is_leap(input logic [15:0] y);
		logic [15:0] prod;
		logic        div25;
		prod  = 16'(y * INV25);
		div25 = (prod <= DIV25_MAX);
		return ((y[3:0] == 4'd0) && div25) || ((y[1:0] == 2'd0) && !div25);
	endfunction

	// Month length; codes outside 1..12 count as 31 days
	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m) inside
			4'd2:                    d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

// ===== design/tick_calendar_and_quantum_timer.sv =====
// Tick-driven calendar clock with a 32-bit uptime counter and a scheduler
// quantum timer. Each request is either a tick (op = OP_TICK), which adds
// tick_millis to uptime, to the scheduler count and to the millisecond field
// and carries one second at most through the Gregorian calendar, or a load
// (op = OP_LOAD), which writes the whole date and time. Every request gives one
// result with the state after the update; schedule_now is set on the tick that
// brings the scheduler count to min_quantum + 10 or more, which clears the count.
// After reset the time is 2000-01-01 00:00:00.000, uptime 0, tick_millis 10,
// min_quantum 0. One request is taken every cycle while in_stall is low; the whole
// update, a single 16-bit multiply for the leap test plus the carry chain, is
// combinational and registered into the state and result registers. A two-entry
// output (result register plus skid) keeps the input open for one more request
// while a result is stalled; input stall rises only when both entries are full.
module tick_calendar_and_quantum_timer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] set_year,
	input  logic [3:0]  set_month,
	input  logic [4:0]  set_day,
	input  logic [4:0]  set_hour,
	input  logic [5:0]  set_minute,
	input  logic [5:0]  set_second,
	input  logic [9:0]  set_milli,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] uptime_ms,
	output logic [15:0] cur_year,
	output logic [3:0]  cur_month,
	output logic [4:0]  cur_day,
	output logic [4:0]  cur_hour,
	output logic [5:0]  cur_minute,
	output logic [5:0]  cur_second,
	output logic [9:0]  cur_milli,
	output logic        schedule_now
);
	import tcqt_pkg::*;

	// configuration and state
	logic [9:0]  tick_millis_q;
	logic [15:0] min_quantum_q;
	logic [31:0] uptime_q;
	logic [16:0] sched_q;
	tod_t        tod_q;

	// output entries
	logic        out_valid_q;
	res_t        out_q;
	logic        skid_valid_q;
	res_t        skid_q;

	// next-state signals
	logic        acc;
	logic        out_take;
	tod_t        tod_nxt;
	logic [31:0] uptime_nxt;
	logic [16:0] sched_nxt;
	logic [16:0] sched_sum;
	logic        pulse;
	logic [10:0] milli_sum;
	logic [10:0] milli_rem;
	logic [6:0]  sec_inc;
	logic [6:0]  min_inc;
	logic [5:0]  hour_inc;
	logic [5:0]  day_inc;
	logic [4:0]  mon_inc;
	logic [4:0]  dim;
	res_t        res;

	assign in_stall = skid_valid_q;
	assign acc      = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;

	// field increments at full width, compared before truncation
	assign milli_sum = {1'b0, tod_q.milli} + {1'b0, tick_millis_q};
	assign milli_rem = milli_sum - MS_PER_SEC;
	assign sec_inc   = {1'b0, tod_q.second} + 7'd1;
	assign min_inc   = {1'b0, tod_q.minute} + 7'd1;
	assign hour_inc  = {1'b0, tod_q.hour} + 6'd1;
	assign day_inc   = {1'b0, tod_q.day} + 6'd1;
	assign mon_inc   = {1'b0, tod_q.month} + 5'd1;
	assign dim       = days_in_month(tod_q.month, is_leap(tod_q.year));
	assign sched_sum = sched_q + {7'd0, tick_millis_q};

	// update for one request
	always_comb begin
		tod_nxt    = tod_q;
		uptime_nxt = uptime_q;
		sched_nxt  = sched_q;
		pulse      = 1'b0;
		if (op == OP_LOAD) begin
			tod_nxt.year   = set_year;
			tod_nxt.month  = set_month;
			tod_nxt.day    = set_day;
			tod_nxt.hour   = set_hour;
			tod_nxt.minute = set_minute;
			tod_nxt.second = set_second;
			tod_nxt.milli  = set_milli;
		end else begin
			uptime_nxt = uptime_q + {22'd0, tick_millis_q};
			// millisecond field; one second carried at most, leftover clamps
			if (milli_sum >= MS_PER_SEC) begin
				tod_nxt.milli = (milli_rem > {1'b0, MILLI_MAX}) ? MILLI_MAX : milli_rem[9:0];
				if (sec_inc < SEC_LIMIT) begin
					tod_nxt.second = sec_inc[5:0];
				end else begin
					tod_nxt.second = 6'd0;
					if (min_inc < MIN_LIMIT) begin
						tod_nxt.minute = min_inc[5:0];
					end else begin
						tod_nxt.minute = 6'd0;
						if (hour_inc < HOUR_LIMIT) begin
							tod_nxt.hour = hour_inc[4:0];
						end else begin
							tod_nxt.hour = 5'd0;
							if (day_inc <= {1'b0, dim}) begin
								tod_nxt.day = day_inc[4:0];
							end else begin
								tod_nxt.day = DAY_RST;
								if (mon_inc <= MONTH_LAST) begin
									tod_nxt.month = mon_inc[3:0];
								end else begin
									tod_nxt.month = MONTH_RST;
									tod_nxt.year  = tod_q.year + 16'd1;
								end
							end
						end
					end
				end
			end else begin
				tod_nxt.milli = milli_sum[9:0];
			end
			// scheduler quantum
			if (sched_sum >= ({1'b0, min_quantum_q} + SCHED_BIAS)) begin
				sched_nxt = 17'd0;
				pulse     = 1'b1;
			end else begin
				sched_nxt = sched_sum;
			end
		end
	end

	assign res.uptime_ms    = uptime_nxt;
	assign res.tod          = tod_nxt;
	assign res.schedule_now = pulse;

	// configuration and timekeeping state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_millis_q <= TICK_MILLIS_RST;
			min_quantum_q <= MIN_QUANTUM_RST;
			uptime_q      <= 32'd0;
			sched_q       <= 17'd0;
			tod_q.year    <= YEAR_RST;
			tod_q.month   <= MONTH_RST;
			tod_q.day     <= DAY_RST;
			tod_q.hour    <= 5'd0;
			tod_q.minute  <= 6'd0;
			tod_q.second  <= 6'd0;
			tod_q.milli   <= 10'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TICK_MILLIS: tick_millis_q <= cfg_data[9:0];
					CFG_MIN_QUANTUM: min_quantum_q <= cfg_data;
					default: ;
				endcase
			end
			if (acc) begin
				uptime_q <= uptime_nxt;
				sched_q  <= sched_nxt;
				tod_q    <= tod_nxt;
			end
		end
	end

	// output entry valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_take) begin
				out_valid_q  <= skid_valid_q || acc;
				skid_valid_q <= 1'b0;
			end else if (acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// output entry payloads
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign uptime_ms    = out_q.uptime_ms;
	assign cur_year     = out_q.tod.year;
	assign cur_month    = out_q.tod.month;
	assign cur_day      = out_q.tod.day;
	assign cur_hour     = out_q.tod.hour;
	assign cur_minute   = out_q.tod.minute;
	assign cur_second   = out_q.tod.second;
	assign cur_milli    = out_q.tod.milli;
	assign schedule_now = out_q.schedule_now;

`ifndef SYNTH
	// skid entry only fills behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty result register");

	// a load leaves uptime and scheduler count alone
	a_load_keeps_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_LOAD) |=> ($stable(uptime_q) && $stable(sched_q)))
		else $error("load changed uptime or scheduler count");

	// an expired quantum restarts the count
	a_pulse_clears_sched: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pulse) |=> (sched_q == 17'd0))
		else $error("scheduler count not cleared after pulse");

	// in-range ticks keep the millisecond field in range
	a_milli_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_TICK && tod_q.milli <= MILLI_MAX
			&& {1'b0, tick_millis_q} <= MS_PER_SEC) |=> (tod_q.milli <= MILLI_MAX))
		else $error("millisecond field left range on tick");
`endif

endmodule
